### rtl/avs_pkg.sv
// avs_pkg: shared constants for the aim vector scaler.
// No dependencies; imported by the interfaces and all rtl modules.
package avs_pkg;

  // Default coordinate word width (two's complement fixed point)
  localparam int unsigned WordBitsDef = 32;

endpackage

### rtl/avs_in_if.sv
// avs_in_if: request channel carrying two points and a speed.
// Depends on avs_pkg for the default word width.
interface avs_in_if
  import avs_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] src_x;
  logic signed [WORD_BITS-1:0] src_y;
  logic signed [WORD_BITS-1:0] dst_x;
  logic signed [WORD_BITS-1:0] dst_y;
  logic signed [WORD_BITS-1:0] speed_mag;

  modport source (output valid, src_x, src_y, dst_x, dst_y, speed_mag, input ready);
  modport sink   (input valid, src_x, src_y, dst_x, dst_y, speed_mag, output ready);
endinterface

### rtl/avs_out_if.sv
// avs_out_if: result channel carrying the scaled vector and the flag.
// Depends on avs_pkg for the default word width.
interface avs_out_if
  import avs_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] vec_x;
  logic signed [WORD_BITS-1:0] vec_y;
  logic                        same_point;

  modport source (output valid, vec_x, vec_y, same_point, input ready);
  modport sink   (input valid, vec_x, vec_y, same_point, output ready);
endinterface

### rtl/avs_front.sv
// avs_front: differences, magnitudes, squares and products, sum of squares.
// Three register stages; depends on avs_pkg.
module avs_front
  import avs_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef,
  localparam int unsigned SW = 2 * WORD_BITS + 2,
  localparam int unsigned NW = 2 * WORD_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 v_i,
  input  logic [WORD_BITS-1:0] src_x_i,
  input  logic [WORD_BITS-1:0] src_y_i,
  input  logic [WORD_BITS-1:0] dst_x_i,
  input  logic [WORD_BITS-1:0] dst_y_i,
  input  logic [WORD_BITS-1:0] speed_i,
  output logic                 v_o,
  output logic [SW-1:0]        sum_o,
  output logic [NW-1:0]        px_o,
  output logic [NW-1:0]        py_o,
  output logic                 negx_o,
  output logic                 negy_o,
  output logic                 zero_o
);
  localparam int unsigned W = WORD_BITS;

  logic [2:0]   v_q;
  logic [W:0]   dx_q, dy_q;
  logic [W-1:0] spd_q;
  logic [W:0]   dx_d, dy_d, ax, ay;
  logic [W-1:0] as_v;
  logic [SW-1:0] sqx_q, sqy_q, sum_q;
  logic [NW-1:0] px_q, py_q, px2_q, py2_q;
  logic [2:0]   nx_q, ny_q, z_q;

  // Exact differences, one bit wider than a word
  assign dx_d = {src_x_i[W-1], src_x_i} - {dst_x_i[W-1], dst_x_i};
  assign dy_d = {src_y_i[W-1], src_y_i} - {dst_y_i[W-1], dst_y_i};

  assign ax   = dx_q[W] ? (W+1)'(-dx_q) : dx_q;
  assign ay   = dy_q[W] ? (W+1)'(-dy_q) : dy_q;
  assign as_v = spd_q[W-1] ? W'(-spd_q) : spd_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], v_i};
    end
  end

  // Payload stages: operands, products, sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      spd_q <= speed_i;
      z_q[0]  <= (dx_d == '0) && (dy_d == '0);
      nx_q[0] <= dx_d[W] ^ speed_i[W-1];
      ny_q[0] <= dy_d[W] ^ speed_i[W-1];

      sqx_q <= SW'(ax) * SW'(ax);
      sqy_q <= SW'(ay) * SW'(ay);
      px_q  <= NW'(ax) * NW'(as_v);
      py_q  <= NW'(ay) * NW'(as_v);
      z_q[1]  <= z_q[0];
      nx_q[1] <= nx_q[0];
      ny_q[1] <= ny_q[0];

      sum_q <= sqx_q + sqy_q;
      px2_q <= px_q;
      py2_q <= py_q;
      z_q[2]  <= z_q[1];
      nx_q[2] <= nx_q[1];
      ny_q[2] <= ny_q[1];
    end
  end

  assign v_o    = v_q[2];
  assign sum_o  = sum_q;
  assign px_o   = px2_q;
  assign py_o   = py2_q;
  assign negx_o = nx_q[2];
  assign negy_o = ny_q[2];
  assign zero_o = z_q[2];
endmodule

### rtl/avs_sqrt_cell.sv
// avs_sqrt_cell: one digit step of the integer square root chain.
// Settles root bit STEP; depends on avs_pkg.
module avs_sqrt_cell
  import avs_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef,
  parameter int unsigned STEP = 0,
  localparam int unsigned SW = 2 * WORD_BITS + 2
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] x_i,
  input  logic [SW-1:0] r_i,
  output logic [SW-1:0] x_o,
  output logic [SW-1:0] r_o
);
  localparam logic [SW-1:0] One = SW'(1) << (2 * STEP);

  logic [SW-1:0] trial;
  logic          take;

  assign trial = r_i + One;
  assign take  = x_i >= trial;

  // Subtract the trial value when it fits, shift the root
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= take ? x_i - trial : x_i;
      r_o <= take ? (r_i >> 1) + One : r_i >> 1;
    end
  end
endmodule

### rtl/avs_div_cell.sv
// avs_div_cell: one restoring step of the quotient chain.
// Settles quotient bit STEP; depends on avs_pkg.
module avs_div_cell
  import avs_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef,
  parameter int unsigned STEP = 0,
  localparam int unsigned NW = 2 * WORD_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NW-1:0]        rem_i,
  input  logic [WORD_BITS:0]   d_i,
  input  logic [WORD_BITS-1:0] q_i,
  output logic [NW-1:0]        rem_o,
  output logic [WORD_BITS:0]   d_o,
  output logic [WORD_BITS-1:0] q_o
);
  logic [NW-1:0] dsh;
  logic          take;

  assign dsh  = NW'(d_i) << STEP;
  assign take = rem_i >= dsh;

  // Subtract the shifted divisor when it fits, set the bit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= take ? rem_i - dsh : rem_i;
      d_o   <= d_i;
      q_o   <= take ? (q_i | (WORD_BITS'(1) << STEP)) : q_i;
    end
  end
endmodule

### rtl/aim_vector_scaler.sv
// aim_vector_scaler: top level, square root and divider cell chains, output stage.
// Depends on avs_pkg, avs_in_if, avs_out_if, avs_front, avs_sqrt_cell, avs_div_cell.
//
// Usage: a request item carries src, dst and a signed speed; the result item
// carries (src - dst) * speed / floor(|src - dst|), truncated toward zero and
// saturated to the word range. When src equals dst the result is a zero
// vector with same_point set.
// Channels: req_i (sink) and rsp_o (source), valid/ready handshakes.
// Throughput: one item per cycle unless stalled; three front stages,
// WORD_BITS+1 square root cells and WORD_BITS x/y divider pairs hold one item each.
// Stall: the whole chain advances only while the output register is empty
// or being taken; a stalled receiver freezes the chain and drops req ready.
// Reset: clears all valid bits; the chain comes up empty and ready.
module aim_vector_scaler
  import avs_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  avs_in_if.sink    req_i,
  avs_out_if.source rsp_o
);
  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned SB = W + 1;
  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned NW = 2 * W + 1;
  localparam logic [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};

  logic en;
  logic out_v_q;
  logic [W-1:0] vx_q, vy_q;
  logic same_q;

  assign en          = !out_v_q || rsp_o.ready;
  assign req_i.ready = en;

  // Front stages
  logic          fv;
  logic [SW-1:0] fsum;
  logic [NW-1:0] fpx, fpy;
  logic          fnx, fny, fz;

  avs_front #(.WORD_BITS(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .v_i     (req_i.valid),
    .src_x_i (req_i.src_x),
    .src_y_i (req_i.src_y),
    .dst_x_i (req_i.dst_x),
    .dst_y_i (req_i.dst_y),
    .speed_i (req_i.speed_mag),
    .v_o     (fv),
    .sum_o   (fsum),
    .px_o    (fpx),
    .py_o    (fpy),
    .negx_o  (fnx),
    .negy_o  (fny),
    .zero_o  (fz)
  );

  // Square root chain, side payload rides along
  logic [SW-1:0] sx [SB+1];
  logic [SW-1:0] sr [SB+1];
  logic [NW-1:0] spx [SB+1];
  logic [NW-1:0] spy [SB+1];
  logic [2:0]    sfl [SB+1];
  logic          sv  [SB+1];

  assign sx[0]  = fsum;
  assign sr[0]  = '0;
  assign spx[0] = fpx;
  assign spy[0] = fpy;
  assign sfl[0] = {fnx, fny, fz};
  assign sv[0]  = fv;

  for (genvar i = 0; i < SB; i++) begin : g_sqrt
    avs_sqrt_cell #(.WORD_BITS(W), .STEP(SB - 1 - i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (sx[i]),
      .r_i   (sr[i]),
      .x_o   (sx[i+1]),
      .r_o   (sr[i+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        spx[i+1] <= spx[i];
        spy[i+1] <= spy[i];
        sfl[i+1] <= sfl[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv[i+1] <= 1'b0;
      end else if (en) begin
        sv[i+1] <= sv[i];
      end
    end
  end

  // Divider chains for both components
  logic [NW-1:0] rx [W+1];
  logic [NW-1:0] ry [W+1];
  logic [W:0]    dxl [W+1];
  logic [W:0]    dyl [W+1];
  logic [W-1:0]  qx [W+1];
  logic [W-1:0]  qy [W+1];
  logic [2:0]    dfl [W+1];
  logic          dv  [W+1];

  assign rx[0]  = spx[SB];
  assign ry[0]  = spy[SB];
  assign dxl[0] = sr[SB][W:0];
  assign dyl[0] = sr[SB][W:0];
  assign qx[0]  = '0;
  assign qy[0]  = '0;
  assign dfl[0] = sfl[SB];
  assign dv[0]  = sv[SB];

  for (genvar j = 0; j < W; j++) begin : g_div
    avs_div_cell #(.WORD_BITS(W), .STEP(W - 1 - j)) u_x (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rx[j]),
      .d_i   (dxl[j]),
      .q_i   (qx[j]),
      .rem_o (rx[j+1]),
      .d_o   (dxl[j+1]),
      .q_o   (qx[j+1])
    );

    avs_div_cell #(.WORD_BITS(W), .STEP(W - 1 - j)) u_y (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (ry[j]),
      .d_i   (dyl[j]),
      .q_i   (qy[j]),
      .rem_o (ry[j+1]),
      .d_o   (dyl[j+1]),
      .q_o   (qy[j+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        dfl[j+1] <= dfl[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
    end
  end

  // Apply sign, saturate, zero on coinciding points
  logic [W-1:0] vx_d, vy_d;
  logic         nx, ny, zf;

  assign nx = dfl[W][2];
  assign ny = dfl[W][1];
  assign zf = dfl[W][0];

  always_comb begin
    if (zf) begin
      vx_d = '0;
      vy_d = '0;
    end else begin
      vx_d = nx ? W'(-qx[W]) : (qx[W][W-1] ? MaxV : qx[W]);
      vy_d = ny ? W'(-qy[W]) : (qy[W][W-1] ? MaxV : qy[W]);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q   <= vx_d;
      vy_q   <= vy_d;
      same_q <= zf;
    end
  end

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.vec_x      = vx_q;
  assign rsp_o.vec_y      = vy_q;
  assign rsp_o.same_point = same_q;

  // Coinciding points always give a zero vector
  a_same_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.same_point |-> (rsp_o.vec_x == '0) && (rsp_o.vec_y == '0))
    else $error("same_point result with nonzero vector");

  // A frozen chain keeps its last valid bit
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv[W]))
    else $error("chain moved while stalled");

  // Hold a waiting result until it is taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.vec_x)
      && $stable(rsp_o.vec_y) && $stable(rsp_o.same_point))
    else $error("result changed while stalled");
endmodule

### tb/tb_pkg.sv
`timescale 1ns / 1ps
// tb_pkg: shared testbench types for the aim vector scaler.
// Depends on avs_pkg for the word width.
package tb_pkg;
  import avs_pkg::*;

  localparam int unsigned WB = WordBitsDef;

  typedef logic signed [WB-1:0] word_t;

  typedef struct packed {
    word_t src_x;
    word_t src_y;
    word_t dst_x;
    word_t dst_y;
    word_t speed_mag;
  } aim_req_t;

  typedef struct packed {
    word_t vec_x;
    word_t vec_y;
    logic  same_point;
  } aim_vec_t;
endpackage

### tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for aim_vector_scaler with random flow control.
// Depends on avs_pkg, tb_pkg, avs_in_if, avs_out_if and the rtl block.
module tb;
  import avs_pkg::*;
  import tb_pkg::*;

  localparam int LATENCY    = 2 * WB + 5;
  localparam int N_RANDOM   = 1330;
  localparam int WATCHDOG   = 20000;
  localparam int N_DIRECTED = 16;

  logic clk_i;
  logic rst_ni;

  avs_in_if  #(.WORD_BITS(WB)) req_if ();
  avs_out_if #(.WORD_BITS(WB)) rsp_if ();

  aim_vector_scaler #(.WORD_BITS(WB)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  aim_vec_t pending_vecs[$];
  int       n_errors;
  int       n_sent;
  int       n_checked;
  int       n_same;
  int       n_clamped;
  int       idle_cycles;
  bit       stim_done;
  bit       hold_rsp;

  // Directed rows: stimulus plus optional typed-in expectation
  typedef struct {
    aim_req_t req;
    bit       has_exp;
    aim_vec_t exp;
  } dir_row_t;
  dir_row_t dir_rows[N_DIRECTED];

  localparam word_t WMAX = {1'b0, {(WB-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WB-1){1'b0}}};
  localparam word_t ONE  = word_t'(1) <<< 16;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Integer square root rounded down, bit by bit
  function automatic logic [WB+1:0] floor_sqrt(logic [2*WB+3:0] s);
    logic [WB+1:0]   r;
    logic [WB+1:0]   c;
    r = '0;
    for (int b = WB + 1; b >= 0; b--) begin
      c = r | ((WB+2)'(1) << b);
      if ((2*WB+4)'(c) * (2*WB+4)'(c) <= s) r = c;
    end
    return r;
  endfunction

  // Scale one component: trunc(d * speed / len), saturated
  function automatic word_t scale_comp(logic signed [WB:0] d, word_t spd, logic [WB+1:0] len);
    logic [WB:0]     ad;
    logic [WB:0]     as;
    logic [2*WB+1:0] q;
    bit              neg;
    ad  = d < 0 ? -d : d;
    as  = spd < 0 ? (WB+1)'(-(WB+1)'(spd)) : (WB+1)'(spd);
    q   = ((2*WB+2)'(ad) * (2*WB+2)'(as)) / (2*WB+2)'(len);
    neg = (d < 0) != (spd < 0);
    if (q == 0) return '0;
    if (neg) begin
      if (q > (2*WB+2)'({1'b1, {(WB-1){1'b0}}})) return WMIN;
      return word_t'(-q);
    end
    if (q > (2*WB+2)'(WMAX)) return WMAX;
    return word_t'(q);
  endfunction

  function automatic aim_vec_t aim_vector(aim_req_t r);
    logic signed [WB:0] dx;
    logic signed [WB:0] dy;
    logic [2*WB+3:0]    sq;
    aim_vec_t           v;
    dx = (WB+1)'(r.src_x) - (WB+1)'(r.dst_x);
    dy = (WB+1)'(r.src_y) - (WB+1)'(r.dst_y);
    dx = $signed({r.src_x[WB-1], r.src_x}) - $signed({r.dst_x[WB-1], r.dst_x});
    dy = $signed({r.src_y[WB-1], r.src_y}) - $signed({r.dst_y[WB-1], r.dst_y});
    if (dx == 0 && dy == 0) return '{vec_x: '0, vec_y: '0, same_point: 1'b1};
    sq = (2*WB+4)'(dx < 0 ? -dx : dx) * (2*WB+4)'(dx < 0 ? -dx : dx)
       + (2*WB+4)'(dy < 0 ? -dy : dy) * (2*WB+4)'(dy < 0 ? -dy : dy);
    v.vec_x      = scale_comp(dx, r.speed_mag, floor_sqrt(sq));
    v.vec_y      = scale_comp(dy, r.speed_mag, floor_sqrt(sq));
    v.same_point = 1'b0;
    return v;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return WMAX;
      1: return WMIN;
      2: return word_t'($signed($urandom_range(0, 64)) - 32);
      3: return word_t'($signed($urandom_range(0, 8)) - 4) <<< 16;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic aim_req_t rand_req();
    aim_req_t r;
    r.src_x     = rand_word();
    r.src_y     = rand_word();
    r.speed_mag = rand_word();
    case ($urandom_range(0, 9))
      0: begin
        r.dst_x = r.src_x;
        r.dst_y = r.src_y;
      end
      1, 2: begin
        // nearby destination, short vectors
        r.dst_x = r.src_x + word_t'($signed($urandom_range(0, 6)) - 3);
        r.dst_y = r.src_y + word_t'($signed($urandom_range(0, 6)) - 3);
      end
      default: begin
        r.dst_x = rand_word();
        r.dst_y = rand_word();
      end
    endcase
    return r;
  endfunction

  task automatic load_directed();
    aim_vec_t z;
    z = '{vec_x: '0, vec_y: '0, same_point: 1'b1};
    dir_rows[0]  = '{'{'0, '0, '0, '0, ONE}, 1'b1, z};
    dir_rows[1]  = '{'{WMAX, WMIN, WMAX, WMIN, WMIN}, 1'b1, z};
    dir_rows[2]  = '{'{ONE, '0, '0, '0, ONE}, 1'b1, '{ONE, '0, 1'b0}};
    dir_rows[3]  = '{'{'0, '0, ONE, '0, ONE}, 1'b1, '{-ONE, '0, 1'b0}};
    // most-negative speed against a negative component clamps high
    dir_rows[4]  = '{'{'0, '0, ONE, '0, WMIN}, 1'b1, '{WMAX, '0, 1'b0}};
    dir_rows[5]  = '{'{ONE, '0, '0, '0, WMIN}, 1'b1, '{WMIN, '0, 1'b0}};
    dir_rows[6]  = '{'{'0, ONE, '0, '0, WMAX}, 1'b1, '{'0, WMAX, 1'b0}};
    dir_rows[7]  = '{'{WMAX, WMAX, WMIN, WMIN, WMAX}, 1'b0, z};
    dir_rows[8]  = '{'{WMIN, WMIN, WMAX, WMAX, WMIN}, 1'b0, z};
    dir_rows[9]  = '{'{WMAX, WMIN, WMIN, WMAX, ONE}, 1'b0, z};
    dir_rows[10] = '{'{3, 4, '0, '0, 5 * ONE}, 1'b0, z};
    dir_rows[11] = '{'{-1, -1, '0, '0, -1}, 1'b0, z};
    dir_rows[12] = '{'{'0, '0, 1, 1, WMIN}, 1'b0, z};
    dir_rows[13] = '{'{'1, '1, '0, '0, '1}, 1'b0, z};
    dir_rows[14] = '{'{WMAX, '0, WMIN, '0, WMIN}, 1'b0, z};
    dir_rows[15] = '{'{'0, WMIN, '0, WMAX, '0}, 1'b0, z};
  endtask

  // Offer one item, hold it until accepted
  task automatic offer_item(aim_req_t r, bit has_exp, aim_vec_t exp);
    req_if.valid     <= 1'b1;
    req_if.src_x     <= r.src_x;
    req_if.src_y     <= r.src_y;
    req_if.dst_x     <= r.dst_x;
    req_if.dst_y     <= r.dst_y;
    req_if.speed_mag <= r.speed_mag;
    do @(posedge clk_i); while (!req_if.ready);
    pending_vecs.push_back(has_exp ? exp : aim_vector(r));
    n_sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 1) == 0) n = 0;
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Sender
  initial begin
    aim_vec_t none;
    none = '0;
    req_if.valid     = 1'b0;
    req_if.src_x     = '0;
    req_if.src_y     = '0;
    req_if.dst_x     = '0;
    req_if.dst_y     = '0;
    req_if.speed_mag = '0;
    rst_ni           = 1'b0;
    load_directed();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < N_DIRECTED; i++)
      offer_item(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);
    req_if.valid <= 1'b0;
    // pause until the pipe drains
    wait (pending_vecs.size() == 0);
    @(posedge clk_i);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) hold_rsp <= 1'b1;
      offer_item(rand_req(), 1'b0, none);
      idle_gap();
    end
    req_if.valid <= 1'b0;
    stim_done    <= 1'b1;
  end

  // Long receiver hold-off, counted here
  initial begin
    hold_rsp = 1'b0;
    wait (hold_rsp);
    repeat (LATENCY * 3) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  // Receiver ready with random stalls
  initial begin
    int n;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) n = 0;
      rsp_if.ready <= 1'b0;
      repeat (n) @(posedge clk_i);
      rsp_if.ready <= !hold_rsp;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    aim_vec_t exp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_vecs.size() == 0) begin
        $error("result with nothing expected");
        n_errors++;
      end else begin
        exp = pending_vecs.pop_front();
        n_checked++;
        if (exp.same_point) n_same++;
        if (!exp.same_point && (exp.vec_x == WMAX || exp.vec_x == WMIN)) n_clamped++;
        if (rsp_if.vec_x !== exp.vec_x) begin
          $error("vec_x exp %0d got %0d", exp.vec_x, rsp_if.vec_x);
          n_errors++;
        end
        if (rsp_if.vec_y !== exp.vec_y) begin
          $error("vec_y exp %0d got %0d", exp.vec_y, rsp_if.vec_y);
          n_errors++;
        end
        if (rsp_if.same_point !== exp.same_point) begin
          $error("same_point exp %0b got %0b", exp.same_point, rsp_if.same_point);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    n_errors    = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_same      = 0;
    n_clamped   = 0;
    idle_cycles = 0;
    stim_done   = 1'b0;
    fork
      begin
        wait (stim_done && pending_vecs.size() == 0);
        repeat (LATENCY + 10) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= WATCHDOG);
        $display("timeout after %0d idle cycles", idle_cycles);
        n_errors++;
      end
    join_any
    if (pending_vecs.size() != 0) begin
      $error("%0d expected results never arrived", pending_vecs.size());
      n_errors++;
    end
    $display("Sent %0d items, checked %0d results (%0d coincident points, %0d at a word limit)",
             n_sent, n_checked, n_same, n_clamped);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### files.f
rtl/avs_pkg.sv
rtl/avs_in_if.sv
rtl/avs_out_if.sv
rtl/avs_front.sv
rtl/avs_sqrt_cell.sv
rtl/avs_div_cell.sv
rtl/aim_vector_scaler.sv
tb/tb_pkg.sv
tb/tb.sv
